FILE: sv/csm_pkg.sv
// Shared constants, codes and types of the closest scan matcher.
package csm_pkg;

  localparam int unsigned MAX_ROWS  = 1024;
  localparam int unsigned ADDR_W    = $clog2(MAX_ROWS);
  localparam int unsigned CNT_W     = ADDR_W + 1;

  localparam int unsigned TIME_W    = 24;
  localparam int unsigned SCAN_W    = 16;
  localparam int unsigned ROW_W     = 10;
  localparam int unsigned FC_W      = 11;
  localparam int unsigned CFG_W     = 24;
  localparam int unsigned CFG_IDX_W = 2;

  // Request types.
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_SCAN = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RT_TOL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DT_TOL    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_EN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FEAT_CNT  = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ROW_W-1:0]  row_index;
    logic [TIME_W-1:0] rt_value;
    logic [TIME_W-1:0] dt_value;
    logic [SCAN_W-1:0] scan_number;
  } csm_req_t;

  typedef struct packed {
    logic [SCAN_W-1:0] closest_scan;
    logic [TIME_W-1:0] closest_rt;
    logic [TIME_W-1:0] closest_dt;
  } csm_res_t;

  typedef struct packed {
    logic [TIME_W-1:0] rt;
    logic [TIME_W-1:0] dt;
  } csm_feat_t;

  typedef struct packed {
    logic [TIME_W-1:0] rt_tol;
    logic [TIME_W-1:0] dt_tol;
    logic              drift_enabled;
    logic [FC_W-1:0]   feature_count;
  } csm_cfg_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic read;
    logic scan_start;
    logic scan_step;
  } csm_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic walk_done;
  } csm_sts_t;

endpackage

FILE: sv/csm_ctrl.sv
// Controller state machine of the closest scan matcher.
module csm_ctrl import csm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] req_type_i,
  input  csm_sts_t   sts_i,
  output csm_cmd_t   cmd_o,
  output logic       busy
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (req_type_i)
            REQ_LOAD: cmd_o.load = 1'b1;
            REQ_READ: cmd_o.read = 1'b1;
            REQ_SCAN: begin
              cmd_o.scan_start = 1'b1;
              state_d          = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.walk_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

FILE: sv/csm_datapath.sv
// Datapath of the closest scan matcher: row tables, walk pointer and match logic.
module csm_datapath import csm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  csm_cmd_t cmd_i,
  input  csm_req_t req_i,
  input  csm_cfg_t cfg_i,
  output csm_sts_t sts_o,
  output logic     res_valid_o,
  output csm_res_t res_o
);

  function automatic logic [TIME_W-1:0] absdiff(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  csm_feat_t feat_mem [MAX_ROWS];
  csm_res_t  best_mem [MAX_ROWS];
  csm_feat_t feat_rd_q;
  csm_res_t  best_rd_q;

  logic [TIME_W-1:0] srt_q, sdt_q;
  logic [SCAN_W-1:0] snum_q;
  logic [CNT_W-1:0]  cur_q, cur_d, cur_inc;
  logic [CNT_W-1:0]  ws_q, ws_d;
  logic [CNT_W-1:0]  limit;
  logic              res_valid_q, res_oob_q;

  logic              row_ok;
  logic [ADDR_W-1:0] row_addr;
  logic              in_range, above, below, hit, walk_done;
  logic [TIME_W-1:0] d, b, e, f;
  logic              upd_rt, upd_dt;
  csm_res_t          best_new;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              best_we, feat_we;
  logic [ADDR_W-1:0] wr_addr;
  csm_res_t          best_wdata;

  assign row_ok   = (32'(req_i.row_index) < MAX_ROWS);
  assign row_addr = ADDR_W'(req_i.row_index);
  assign cur_inc  = cur_q + CNT_W'(1);

  always_comb begin
    if (32'(cfg_i.feature_count) >= MAX_ROWS) begin
      limit = CNT_W'(MAX_ROWS);
    end else begin
      limit = CNT_W'(cfg_i.feature_count);
    end
  end

  // Row under test is the one whose data came out of the tables this cycle.
  assign in_range  = (cur_q < limit);
  assign above     = ({1'b0, srt_q} + {1'b0, cfg_i.rt_tol}) < {1'b0, feat_rd_q.rt};
  assign below     = ({1'b0, feat_rd_q.rt} + {1'b0, cfg_i.rt_tol}) < {1'b0, srt_q};
  assign walk_done = !in_range || above;
  assign hit       = cmd_i.scan_step && !walk_done && !below;

  assign d = absdiff(feat_rd_q.rt, srt_q);
  assign b = absdiff(feat_rd_q.rt, best_rd_q.closest_rt);
  assign e = absdiff(feat_rd_q.dt, sdt_q);
  assign f = absdiff(feat_rd_q.dt, best_rd_q.closest_dt);

  // Both tests compare against the stored distance from before this scan.
  assign upd_rt = ({1'b0, d} + {{TIME_W{1'b0}}, 1'b1}) < {1'b0, b};
  assign upd_dt = cfg_i.drift_enabled && (d <= b) && (e < f) && (e < cfg_i.dt_tol);

  always_comb begin
    best_new = best_rd_q;
    if (upd_rt) begin
      best_new.closest_rt = srt_q;
      if (!cfg_i.drift_enabled) begin
        best_new.closest_scan = snum_q;
      end
    end
    if (upd_dt) begin
      best_new.closest_dt   = sdt_q;
      best_new.closest_scan = snum_q;
    end
  end

  always_comb begin
    rd_en   = cmd_i.read || cmd_i.scan_start || (cmd_i.scan_step && !walk_done);
    rd_addr = cur_inc[ADDR_W-1:0];
    if (cmd_i.read) begin
      rd_addr = row_addr;
    end else if (cmd_i.scan_start) begin
      rd_addr = ws_q[ADDR_W-1:0];
    end
  end

  always_comb begin
    feat_we    = cmd_i.load && row_ok;
    best_we    = feat_we || cmd_i.clear_step || hit;
    wr_addr    = cur_q[ADDR_W-1:0];
    best_wdata = '0;
    if (cmd_i.load) begin
      wr_addr = row_addr;
    end else if (hit) begin
      best_wdata = best_new;
    end
  end

  always_comb begin
    cur_d = cur_q;
    ws_d  = ws_q;
    if (cmd_i.clear_step) begin
      cur_d = cur_inc;
    end else if (cmd_i.scan_start) begin
      cur_d = ws_q;
    end else if (cmd_i.scan_step && !walk_done) begin
      cur_d = cur_inc;
      if (below) begin
        ws_d = ws_q + CNT_W'(1);
      end
    end
    if (feat_we) begin
      ws_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (feat_we) begin
      feat_mem[wr_addr] <= '{rt: req_i.rt_value, dt: req_i.dt_value};
    end
    if (rd_en) begin
      feat_rd_q <= feat_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (best_we) begin
      best_mem[wr_addr] <= best_wdata;
    end
    if (rd_en) begin
      best_rd_q <= best_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      srt_q  <= req_i.rt_value;
      sdt_q  <= req_i.dt_value;
      snum_q <= req_i.scan_number;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      ws_q        <= '0;
      res_valid_q <= 1'b0;
      res_oob_q   <= 1'b0;
    end else begin
      cur_q       <= cur_d;
      ws_q        <= ws_d;
      res_valid_q <= cmd_i.read;
      res_oob_q   <= cmd_i.read && !row_ok;
    end
  end

  assign sts_o.clear_last = (cur_q == CNT_W'(MAX_ROWS - 1));
  assign sts_o.walk_done  = walk_done;
  assign res_valid_o      = res_valid_q;
  assign res_o            = res_oob_q ? '0 : best_rd_q;

endmodule

FILE: sv/closest_scan_matcher_top.sv
// Top level of the closest scan matcher: configuration registers and unit wiring.
//
// Requests enter on req_i and are taken at a rising edge with start high and busy low.
// A load request writes a feature row, clears its best match and rewinds the window
// start; it gives no result. A read request returns the row's best scan, retention
// and drift time on res_o, with res_strobe_o registered from the request and high for
// a single cycle; the receiver cannot hold a result off, and a new request may be taken
// in that same cycle. A scan request walks the feature rows from the window start, one
// row per cycle through the row tables' read port, and keeps busy high while it
// visits the rows and makes the row or limit check that ends the walk.
// Configuration writes on cfg_we_i, cfg_idx_i and cfg_data_i take effect at the
// next edge and are to be made by the user while no scan is in progress; the block
// itself does not enforce this.
// After reset the control and configuration registers are zero and the block clears
// the best-match table, all MAX_ROWS (1024) rows, one row per cycle with busy high,
// before it takes the first request.
module closest_scan_matcher_top import csm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  csm_req_t             req_i,
  output logic                 busy,
  output logic                 res_strobe_o,
  output csm_res_t             res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  csm_cfg_t cfg_q;
  csm_cmd_t cmd;
  csm_sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RT_TOL:   cfg_q.rt_tol        <= cfg_data_i[TIME_W-1:0];
        CFG_DT_TOL:   cfg_q.dt_tol        <= cfg_data_i[TIME_W-1:0];
        CFG_DRIFT_EN: cfg_q.drift_enabled <= cfg_data_i[0];
        CFG_FEAT_CNT: cfg_q.feature_count <= cfg_data_i[FC_W-1:0];
        default: ;
      endcase
    end
  end

  csm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_i.req_type),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  csm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_i       (cfg_q),
    .sts_o       (sts),
    .res_valid_o (res_strobe_o),
    .res_o       (res_o)
  );

`ifndef SYNTH
  // A result appears only in the cycle right after a read request was taken.
  a_res_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(start && !busy && (req_i.req_type == REQ_READ)))
    else $error("result strobe without a preceding read request");

  // A taken scan request always raises busy and so holds off the next request.
  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.req_type == REQ_SCAN)) |=> busy)
    else $error("scan request taken without raising busy");

  // Loads and reads never raise busy.
  a_short_reqs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && ((req_i.req_type == REQ_LOAD) || (req_i.req_type == REQ_READ)))
    |=> !busy)
    else $error("load or read request raised busy");
`endif

endmodule
